// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the heap unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define AMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define AMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AMH_ASSERT(lbl, prop, msg)
`define AMH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/amh_pkg.sv -----
// Shared constants, status codes and the key order of the heap unit.
package amh_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int          KEY_W        = 32;
    localparam int          STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Magnitude as unsigned; the most negative key maps to 2^31.
    function automatic logic [KEY_W-1:0] key_mag(input logic [KEY_W-1:0] k);
        return k[KEY_W-1] ? (~k + 1'b1) : k;
    endfunction

    // True when key a must sit above key b.
    function automatic logic ranks_before(input logic [KEY_W-1:0] a,
                                          input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] ma;
        logic [KEY_W-1:0] mb;
        ma = key_mag(a);
        mb = key_mag(b);
        if (ma != mb) begin
            return ma < mb;
        end
        return a[KEY_W-1] && !b[KEY_W-1] && (b != '0);
    endfunction

endpackage

// ----- rtl/amh_if.sv -----
// Request and response channels of the heap unit.
interface amh_req_if
    import amh_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface amh_rsp_if
    import amh_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    removed_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output removed_value, output status, input ready);
    modport sink   (input valid, input removed_value, input status, output ready);
endinterface

// ----- rtl/abs_value_min_heap_unit.sv -----
// Binary min-heap priority queue ordered by key magnitude, negative key first on a tie.
// Insert: UP_RD and UP_CMP repeat once per level climbed until the key rests or reaches the
// root, then FINISH loads the registered result that drives rsp.valid.
// Remove: RM_ROOT, RM_LAST and DN_LOAD, then DN_CHK, DN_RDR and DN_CMP per level descended;
// rejected items (remove on empty, insert on full) go straight to FINISH.
// One word at a time: the next word can be taken in the same cycle that rsp.valid rises (later while
// the previous result waits); rst_n (async, active low) empties the heap, memory kept.
`include "assert_macros.svh"

module abs_value_min_heap_unit
    import amh_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    amh_req_if.sink   req,
    amh_rsp_if.source rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        IDLE,
        UP_RD,
        UP_CMP,
        RM_ROOT,
        RM_LAST,
        DN_LOAD,
        DN_CHK,
        DN_RDR,
        DN_CMP,
        FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    left_reg, left_next;
    logic [KEY_W-1:0]    res_value_reg, res_value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    // Key memory: slot i of the heap lives at address i-1.
    logic [KEY_W-1:0]    mem [CAPACITY];
    logic [KEY_W-1:0]    rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [AW-1:0]       mem_ra;
    logic [KEY_W-1:0]    mem_wd;

    logic [CW:0]         left_idx;
    logic [CW:0]         right_idx;
    logic                right_ok;
    logic                pick_right;
    logic [KEY_W-1:0]    pick_val;
    logic [CW-1:0]       pick_idx;

    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] idx);
        logic [CW-1:0] t;
        t = idx - CW'(1);
        return t[AW-1:0];
    endfunction

    assign req.ready         = (state_reg == IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_value_reg;
    assign rsp.status        = out_status_reg;

    // Child indexes carry one extra bit so 2i never wraps.
    assign left_idx   = {idx_reg, 1'b0};
    assign right_idx  = left_idx + 1'b1;
    assign right_ok   = (right_idx <= {1'b0, count_reg});
    assign pick_right = right_ok && !ranks_before(left_reg, rd_data_reg);
    assign pick_val   = pick_right ? rd_data_reg : left_reg;
    assign pick_idx   = pick_right ? right_idx[CW-1:0] : left_idx[CW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        left_next       = left_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_wa          = slot_of(idx_reg);
        mem_wd          = key_reg;
        mem_ra          = slot_of(CW'(1));

        case (state_reg)
            IDLE:
            begin
                if (req.valid)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    if (!req.action)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = FINISH;
                        end
                        else
                        begin
                            // Open a hole at the new last slot and climb from there.
                            count_next = count_reg + 1'b1;
                            idx_next   = count_reg + 1'b1;
                            key_next   = req.value;
                            state_next = UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = FINISH;
                    end
                    else
                    begin
                        state_next = RM_ROOT;
                    end
                end
            end
            UP_RD:
            begin
                mem_ra = slot_of(idx_reg >> 1);
                if (idx_reg == CW'(1))
                begin
                    mem_we     = 1'b1;
                    state_next = FINISH;
                end
                else
                begin
                    state_next = UP_CMP;
                end
            end
            UP_CMP:
            begin
                mem_we = 1'b1;
                if (ranks_before(key_reg, rd_data_reg))
                begin
                    // Move the parent down into the hole and climb.
                    mem_wd     = rd_data_reg;
                    idx_next   = idx_reg >> 1;
                    state_next = UP_RD;
                end
                else
                begin
                    state_next = FINISH;
                end
            end
            RM_ROOT:
            begin
                mem_ra     = slot_of(CW'(1));
                state_next = RM_LAST;
            end
            RM_LAST:
            begin
                mem_ra         = slot_of(count_reg);
                res_value_next = rd_data_reg;
                count_next     = count_reg - 1'b1;
                state_next     = DN_LOAD;
            end
            DN_LOAD:
            begin
                key_next   = rd_data_reg;
                idx_next   = CW'(1);
                state_next = (count_reg == '0) ? FINISH : DN_CHK;
            end
            DN_CHK:
            begin
                mem_ra = slot_of(left_idx[CW-1:0]);
                if (left_idx > {1'b0, count_reg})
                begin
                    mem_we     = 1'b1;
                    state_next = FINISH;
                end
                else
                begin
                    state_next = DN_RDR;
                end
            end
            DN_RDR:
            begin
                left_next  = rd_data_reg;
                mem_ra     = slot_of(right_idx[CW-1:0]);
                state_next = DN_CMP;
            end
            DN_CMP:
            begin
                mem_we = 1'b1;
                if (ranks_before(key_reg, pick_val))
                begin
                    state_next = FINISH;
                end
                else
                begin
                    // Pull the chosen child up into the hole and descend.
                    mem_wd     = pick_val;
                    idx_next   = pick_idx;
                    state_next = DN_CHK;
                end
            end
            FINISH:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            key_reg        <= '0;
            left_reg       <= '0;
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            key_reg        <= key_next;
            left_reg       <= left_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    `AMH_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `AMH_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
        "accepted a word but did not go busy")
    `AMH_ASSERT(a_empty_zero,
        (out_valid_reg && (out_status_reg == ST_EMPTY)) |-> (out_value_reg == '0),
        "empty remove returned a nonzero key")
    `AMH_ASSERT(a_count_step,
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)),
        "entry count jumped")
    `AMH_ASSERT(a_load_from_finish, $rose(out_valid_reg) |-> $past(state_reg == FINISH),
        "result loaded outside finish")

endmodule
